[design/acl_fm_pkg.sv]
package acl_fm_pkg;

    // Default number of rule slots
    localparam int RULES_DEFAULT = 16;

    // Field widths
    localparam int KIND_W   = 2;
    localparam int INDEX_W  = 4;
    localparam int ADDR_W   = 32;
    localparam int PORT_W   = 16;
    localparam int PROTO_W  = 8;
    localparam int IFACE_W  = 8;
    localparam int DIR_W    = 2;
    localparam int PREFIX_W = 6;

    // Word kinds
    localparam logic [KIND_W-1:0] KIND_PERMIT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DENY     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLASSIFY = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR    = 2'd3;

    // Direction and prefix codes
    localparam logic [DIR_W-1:0]    DIR_BOTH   = 2'd2;
    localparam logic [PREFIX_W-1:0] PREFIX_ANY = 6'd33;

    // One rule record, also used to hold the packet under test (128 bits)
    typedef struct packed {
        logic [ADDR_W-1:0]   src_addr;
        logic [ADDR_W-1:0]   dst_addr;
        logic [PORT_W-1:0]   src_port;
        logic [PORT_W-1:0]   dst_port;
        logic [PROTO_W-1:0]  protocol;
        logic [IFACE_W-1:0]  iface;
        logic [DIR_W-1:0]    direction;
        logic                mac_flag;
        logic [PREFIX_W-1:0] src_prefix;
        logic [PREFIX_W-1:0] dst_prefix;
        logic                deny;
    } rule_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic wr_rule;
        logic clr;
        logic load_pkt;
        logic scan_start;
        logic scan;
        logic capture;
        logic load_out;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic fw_enable;
        logic match;
        logic scan_done;
    } status_t;

endpackage

[design/acl_fm_pkt_if.sv]
interface acl_fm_pkt_if;

    logic                                valid;
    logic                                ready;
    logic [acl_fm_pkg::KIND_W-1:0]       kind;
    logic [acl_fm_pkg::INDEX_W-1:0]      index;
    logic [acl_fm_pkg::ADDR_W-1:0]       src_addr;
    logic [acl_fm_pkg::ADDR_W-1:0]       dst_addr;
    logic [acl_fm_pkg::PORT_W-1:0]       src_port;
    logic [acl_fm_pkg::PORT_W-1:0]       dst_port;
    logic [acl_fm_pkg::PROTO_W-1:0]      protocol;
    logic [acl_fm_pkg::IFACE_W-1:0]      iface;
    logic [acl_fm_pkg::DIR_W-1:0]        direction;
    logic                                mac_flag;
    logic [acl_fm_pkg::PREFIX_W-1:0]     src_prefix;
    logic [acl_fm_pkg::PREFIX_W-1:0]     dst_prefix;

    modport source (
        output valid, kind, index, src_addr, dst_addr, src_port, dst_port,
               protocol, iface, direction, mac_flag, src_prefix, dst_prefix,
        input  ready
    );

    modport sink (
        input  valid, kind, index, src_addr, dst_addr, src_port, dst_port,
               protocol, iface, direction, mac_flag, src_prefix, dst_prefix,
        output ready
    );

endinterface

[design/acl_fm_res_if.sv]
interface acl_fm_res_if;

    logic                            valid;
    logic                            ready;
    logic                            verdict;
    logic                            hit;
    logic [acl_fm_pkg::INDEX_W-1:0]  hit_index;

    modport source (
        output valid, verdict, hit, hit_index,
        input  ready
    );

    modport sink (
        input  valid, verdict, hit, hit_index,
        output ready
    );

endinterface

[design/acl_first_match_packet_filter.sv]
// IPv4 first-match access-control list with RULES rule slots. Each word on
// pkt either writes a permit or deny rule into a slot (slots at or above
// RULES are ignored), clears the table, or classifies a packet; only a
// classify returns a word on res. A classify walks the slots from index 0
// upward through one shared rule comparator fed by the rule memory's single
// registered read port, one slot per cycle, and stops at the first valid
// match: it is accepted, each slot is read from memory and then compared,
// and the result is loaded into the output word, finishing early when a
// slot hits. With the firewall disabled a classify skips the scan and
// returns permit. A new word is accepted while the last result still waits
// on res. Rule contents are not cleared by reset; per-slot valid bits are,
// so no clearing pass is needed.
module acl_first_match_packet_filter #(
    parameter int RULES = acl_fm_pkg::RULES_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic         cfg_wr_data,
    acl_fm_pkt_if.sink   pkt,
    acl_fm_res_if.source res
);

    acl_fm_pkg::cmd_t    cmd;
    acl_fm_pkg::status_t status;
    acl_fm_pkg::rule_t   in_word;

    // Packed rule record from the input word
    always_comb
    begin
        in_word.src_addr   = pkt.src_addr;
        in_word.dst_addr   = pkt.dst_addr;
        in_word.src_port   = pkt.src_port;
        in_word.dst_port   = pkt.dst_port;
        in_word.protocol   = pkt.protocol;
        in_word.iface      = pkt.iface;
        in_word.direction  = pkt.direction;
        in_word.mac_flag   = pkt.mac_flag;
        in_word.src_prefix = pkt.src_prefix;
        in_word.dst_prefix = pkt.dst_prefix;
        in_word.deny       = (pkt.kind == acl_fm_pkg::KIND_DENY);
    end

    acl_fm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pkt.valid),
        .in_kind   (pkt.kind),
        .in_ready  (pkt.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .cmd       (cmd),
        .status    (status)
    );

    acl_fm_dp #(
        .RULES (RULES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_word       (in_word),
        .in_index      (pkt.index),
        .cmd           (cmd),
        .status        (status),
        .out_verdict   (res.verdict),
        .out_hit       (res.hit),
        .out_hit_index (res.hit_index)
    );

endmodule

[design/acl_fm_ctrl.sv]
module acl_fm_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [acl_fm_pkg::KIND_W-1:0] in_kind,
    output logic                          in_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    output acl_fm_pkg::cmd_t              cmd,
    input  acl_fm_pkg::status_t           status
);

    acl_fm_pkg::state_t state_reg;
    acl_fm_pkg::state_t state_next;
    logic               out_vld_reg;
    logic               out_vld_next;
    logic               in_fire;

    assign in_fire = in_valid && (state_reg == acl_fm_pkg::ST_IDLE);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            acl_fm_pkg::ST_IDLE:
            begin
                if (in_valid && in_kind == acl_fm_pkg::KIND_CLASSIFY)
                begin
                    if (status.fw_enable)
                        state_next = acl_fm_pkg::ST_SCAN;
                    else
                        state_next = acl_fm_pkg::ST_DONE;
                end
            end
            acl_fm_pkg::ST_SCAN:
            begin
                if (status.scan_done)
                    state_next = acl_fm_pkg::ST_DONE;
            end
            acl_fm_pkg::ST_DONE:
            begin
                if (!out_vld_reg || out_ready)
                    state_next = acl_fm_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = acl_fm_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            acl_fm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (in_kind) inside
                        acl_fm_pkg::KIND_PERMIT, acl_fm_pkg::KIND_DENY:
                        begin
                            cmd.wr_rule = 1'b1;
                        end
                        acl_fm_pkg::KIND_CLEAR:
                        begin
                            cmd.clr = 1'b1;
                        end
                        default:
                        begin
                            // classify: default verdict right away when disabled
                            cmd.load_pkt   = 1'b1;
                            cmd.scan_start = status.fw_enable;
                            cmd.capture    = !status.fw_enable;
                        end
                    endcase
                end
            end
            acl_fm_pkg::ST_SCAN:
            begin
                cmd.scan    = 1'b1;
                cmd.capture = status.scan_done;
            end
            acl_fm_pkg::ST_DONE:
            begin
                cmd.load_out = !out_vld_reg || out_ready;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // Result word valid
    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (cmd.load_out)
            out_vld_next = 1'b1;
        else if (out_ready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= acl_fm_pkg::ST_IDLE;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

    assign out_valid = out_vld_reg;

    // Disabled firewall goes straight to the result
    a_disabled_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_kind == acl_fm_pkg::KIND_CLASSIFY && !status.fw_enable)
            |=> (state_reg == acl_fm_pkg::ST_DONE))
        else $error("disabled classify did not go to result");

    // End of scan hands over to the result stage
    a_scan_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == acl_fm_pkg::ST_SCAN && status.scan_done)
            |=> (state_reg == acl_fm_pkg::ST_DONE))
        else $error("scan end not followed by result stage");

    // A finished result waits while the output word is still held
    a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == acl_fm_pkg::ST_DONE && out_vld_reg && !out_ready)
            |=> (state_reg == acl_fm_pkg::ST_DONE && out_vld_reg))
        else $error("result overwrote a pending output word");

endmodule

[design/acl_fm_dp.sv]
module acl_fm_dp #(
    parameter int RULES = acl_fm_pkg::RULES_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic                           cfg_wr_data,
    input  acl_fm_pkg::rule_t              in_word,
    input  logic [acl_fm_pkg::INDEX_W-1:0] in_index,
    input  acl_fm_pkg::cmd_t               cmd,
    output acl_fm_pkg::status_t            status,
    output logic                           out_verdict,
    output logic                           out_hit,
    output logic [acl_fm_pkg::INDEX_W-1:0] out_hit_index
);

    localparam int AW = (RULES > 1) ? $clog2(RULES) : 1;
    localparam logic [AW-1:0] LAST = AW'(RULES - 1);

    // Mask with the top len bits set; len of 32 and above is a full mask
    function automatic logic [acl_fm_pkg::ADDR_W-1:0] prefix_mask(
        input logic [acl_fm_pkg::PREFIX_W-1:0] len
    );
        logic [acl_fm_pkg::ADDR_W-1:0] m;
        if (len == '0)
            m = '0;
        else if (len >= 6'd32)
            m = '1;
        else
            m = {acl_fm_pkg::ADDR_W{1'b1}} << (6'd32 - len);
        return m;
    endfunction

    function automatic logic rule_match(
        input acl_fm_pkg::rule_t r,
        input acl_fm_pkg::rule_t p
    );
        logic [acl_fm_pkg::DIR_W-1:0] rdir;
        logic                         ok;
        // direction code three in a rule acts as both
        rdir = (r.direction > acl_fm_pkg::DIR_BOTH) ? acl_fm_pkg::DIR_BOTH : r.direction;
        ok   = 1'b1;
        if (r.mac_flag && !p.mac_flag)
            ok = 1'b0;
        if (r.iface != '0 && r.iface != p.iface)
            ok = 1'b0;
        if (rdir != acl_fm_pkg::DIR_BOTH && rdir != p.direction)
            ok = 1'b0;
        if (r.src_prefix != acl_fm_pkg::PREFIX_ANY
            && r.src_addr != (p.src_addr & prefix_mask(r.src_prefix)))
            ok = 1'b0;
        if (r.dst_prefix != acl_fm_pkg::PREFIX_ANY
            && r.dst_addr != (p.dst_addr & prefix_mask(r.dst_prefix)))
            ok = 1'b0;
        if (r.src_port != '0 && r.src_port != p.src_port)
            ok = 1'b0;
        if (r.dst_port != '0 && r.dst_port != p.dst_port)
            ok = 1'b0;
        if (r.protocol != '0 && r.protocol != p.protocol)
            ok = 1'b0;
        return ok;
    endfunction

    acl_fm_pkg::rule_t              mem [RULES];
    acl_fm_pkg::rule_t              rd_reg;
    acl_fm_pkg::rule_t              pkt_reg;
    logic [RULES-1:0]               valid_reg;
    logic [RULES-1:0]               valid_next;
    logic                           fw_en_reg;
    logic [AW-1:0]                  ptr_reg;
    logic [AW-1:0]                  ptr_next;
    logic                           issue_reg;
    logic                           issue_next;
    logic                           cmp_vld_reg;
    logic [AW-1:0]                  cmp_idx_reg;
    logic                           res_verdict_reg;
    logic                           res_hit_reg;
    logic [acl_fm_pkg::INDEX_W-1:0] res_idx_reg;
    logic                           out_verdict_reg;
    logic                           out_hit_reg;
    logic [acl_fm_pkg::INDEX_W-1:0] out_idx_reg;
    logic                           wr_en;
    logic [AW-1:0]                  wr_addr;
    logic                           match;

    // Rule writes beyond the table are dropped
    assign wr_en   = cmd.wr_rule && (32'(in_index) < RULES);
    assign wr_addr = AW'(in_index);

    // Rule memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= in_word;
        rd_reg <= mem[ptr_reg];
    end

    // Valid bits
    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.clr)
            valid_next = '0;
        else if (wr_en)
            valid_next[wr_addr] = 1'b1;
    end

    // Scan pointer: one slot read per cycle, stops after the last slot
    always_comb
    begin
        ptr_next   = ptr_reg;
        issue_next = issue_reg;
        if (cmd.scan_start)
        begin
            ptr_next   = '0;
            issue_next = 1'b1;
        end
        else if (cmd.scan && issue_reg)
        begin
            if (ptr_reg == LAST)
                issue_next = 1'b0;
            else
                ptr_next = ptr_reg + 1'b1;
        end
    end

    // Compare stage on the registered read word
    assign match = cmp_vld_reg && valid_reg[cmp_idx_reg] && rule_match(rd_reg, pkt_reg);

    assign status.fw_enable = fw_en_reg;
    assign status.match     = match;
    assign status.scan_done = match || (cmp_vld_reg && cmp_idx_reg == LAST);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            fw_en_reg   <= 1'b0;
            ptr_reg     <= '0;
            issue_reg   <= 1'b0;
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            ptr_reg     <= ptr_next;
            issue_reg   <= issue_next;
            cmp_vld_reg <= cmd.scan && issue_reg;
            if (cfg_wr_en)
                fw_en_reg <= cfg_wr_data;
        end
    end

    // Packet, compare index and result payload
    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= ptr_reg;
        if (cmd.load_pkt)
            pkt_reg <= in_word;
        if (cmd.capture)
        begin
            res_verdict_reg <= cmd.scan && match && rd_reg.deny;
            res_hit_reg     <= cmd.scan && match;
            res_idx_reg     <= (cmd.scan && match) ? acl_fm_pkg::INDEX_W'(cmp_idx_reg) : '0;
        end
        if (cmd.load_out)
        begin
            out_verdict_reg <= res_verdict_reg;
            out_hit_reg     <= res_hit_reg;
            out_idx_reg     <= res_idx_reg;
        end
    end

    assign out_verdict   = out_verdict_reg;
    assign out_hit       = out_hit_reg;
    assign out_hit_index = out_idx_reg;

    // A clear leaves no rule valid
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr |=> (valid_reg == '0))
        else $error("rule table not empty after clear");

endmodule
